@@ src/hcat_pkg.sv @@
package hcat_pkg;

    localparam int unsigned CapacityDefault = 512;
    localparam logic [31:0] StoreTimeReset  = 32'd10800;
    localparam int unsigned QueueDepth      = 2;

    typedef enum logic [2:0] {
        CMD_HEARD  = 3'd0,
        CMD_CHECK  = 3'd1,
        CMD_DROP   = 3'd2,
        CMD_EXPIRE = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] key_hash;
        logic [63:0] call_low;
        logic [7:0]  call_high;
        logic [3:0]  key_len;
        logic [31:0] time_now;
        logic        keyed;
    } job_t;

    typedef struct packed {
        logic       found;
        logic       status;
        logic [9:0] entry_count;
        logic [9:0] removed_count;
    } res_t;

    // Stored entry: valid mark, hash, bytes, length, last heard.
    typedef struct packed {
        logic        valid;
        logic [31:0] hash;
        logic [63:0] call_low;
        logic [7:0]  call_high;
        logic [3:0]  key_len;
        logic [31:0] heard_at;
    } entry_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_WRITE,
        ST_WIPE,
        ST_DONE
    } state_t;

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5A)
            return b + 8'd32;
        return b;
    endfunction

    function automatic logic key_match(input entry_t e, input job_t j);
        logic ok;
        logic [7:0] a;
        logic [7:0] c;
        ok = (e.hash == j.key_hash) && (e.key_len == j.key_len);
        for (int k = 0; k < 9; k++)
        begin
            a = (k < 8) ? j.call_low[8*k +: 8] : j.call_high;
            c = (k < 8) ? e.call_low[8*k +: 8] : e.call_high;
            if (k < int'(j.key_len) && fold_case(a) != fold_case(c))
                ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

@@ src/heard_callsign_aging_table_core.sv @@
// Table of up to CAPACITY heard callsigns with last-heard times. A front stage
// takes and classifies commands into a two-item queue; a back sequencer walks
// the entry RAM (valid mark stored per entry) slot by slot, with a read state
// and a compare state for each slot. Heard, check and drop end the walk early
// on a hit; a heard that misses then writes its key into the first free slot.
// Expire always walks every slot, clear wipes every slot, and unknown codes go
// straight to the result.
// After reset the back walks all CAPACITY slots once to clear them before it
// takes its first item; the queue still takes two items meanwhile.
// The user must write store_time over the cfg channel only while idle; no logic enforces it.
module heard_callsign_aging_table_core #(
    parameter int unsigned CAPACITY = hcat_pkg::CapacityDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[2:0], key_hash[34:3], call_low[98:35], call_high[106:99],
    // key_len[110:107], time_now[142:111], zero fill to 144
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found[0], status[1], entry_count[11:2], removed_count[21:12], zero fill
    output logic [23:0]  m_tdata
);

    logic [31:0] store_time_reg;
    logic job_valid, job_ready;
    hcat_pkg::job_t job;
    hcat_pkg::res_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            store_time_reg <= hcat_pkg::StoreTimeReset;
        else if (cfg_valid)
            store_time_reg <= cfg_data;
    end

    hcat_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_cmd       (s_tdata[2:0]),
        .in_key_hash  (s_tdata[34:3]),
        .in_call_low  (s_tdata[98:35]),
        .in_call_high (s_tdata[106:99]),
        .in_key_len   (s_tdata[110:107]),
        .in_time_now  (s_tdata[142:111]),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job)
    );

    hcat_back #(.CAPACITY(CAPACITY)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .store_time (store_time_reg),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {2'b00, res.removed_count, res.entry_count, res.status, res.found};

endmodule

@@ src/hcat_ram.sv @@
module hcat_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/hcat_front.sv @@
module hcat_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_cmd,
    input  logic [31:0]         in_key_hash,
    input  logic [63:0]         in_call_low,
    input  logic [7:0]          in_call_high,
    input  logic [3:0]          in_key_len,
    input  logic [31:0]         in_time_now,
    output logic                job_valid,
    input  logic                job_ready,
    output hcat_pkg::job_t      job
);

    localparam int unsigned PtrW = $clog2(hcat_pkg::QueueDepth);

    hcat_pkg::job_t q_reg [hcat_pkg::QueueDepth];
    logic [PtrW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [PtrW:0]   cnt_reg, cnt_next;
    hcat_pkg::job_t  cls;
    logic push, pop;

    // Classify: whether a key search is needed.
    always_comb
    begin
        cls.cmd       = in_cmd;
        cls.key_hash  = in_key_hash;
        cls.call_low  = in_call_low;
        cls.call_high = in_call_high;
        cls.key_len   = in_key_len;
        cls.time_now  = in_time_now;
        cls.keyed     = (in_cmd inside {hcat_pkg::CMD_HEARD, hcat_pkg::CMD_CHECK,
                          hcat_pkg::CMD_DROP});
    end

    assign in_ready  = (cnt_reg != (PtrW+1)'(hcat_pkg::QueueDepth));
    assign job_valid = (cnt_reg != '0);
    assign job       = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= cls;
    end

endmodule

@@ src/hcat_back.sv @@
module hcat_back #(
    parameter int unsigned CAPACITY = hcat_pkg::CapacityDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       store_time,
    input  logic              job_valid,
    output logic              job_ready,
    input  hcat_pkg::job_t    job,
    output logic              res_valid,
    input  logic              res_ready,
    output hcat_pkg::res_t    res
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = $bits(hcat_pkg::entry_t);

    hcat_pkg::state_t state_reg, state_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] removed_reg, removed_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] free_reg, free_next;
    logic          free_ok_reg, free_ok_next;
    logic          found_reg, found_next;
    logic          status_reg, status_next;
    hcat_pkg::job_t job_reg, job_next;
    hcat_pkg::res_t res_reg, res_next;
    logic          out_reg, out_next;
    logic          last;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    hcat_pkg::entry_t wr_data, rd_data;
    logic          age_on;
    logic [31:0]   below;
    logic          hit;

    hcat_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign res_valid = out_reg;
    assign res       = res_reg;
    assign job_ready = (state_reg == hcat_pkg::ST_IDLE);
    assign last      = (idx_reg == AW'(CAPACITY - 1));
    assign age_on    = (store_time <= job_reg.time_now);
    assign below     = job_reg.time_now - store_time;
    assign hit       = rd_data.valid && hcat_pkg::key_match(rd_data, job_reg);

    always_comb
    begin
        state_next   = state_reg;
        total_next   = total_reg;
        removed_next = removed_reg;
        idx_next     = idx_reg;
        free_next    = free_reg;
        free_ok_next = free_ok_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        job_next     = job_reg;
        res_next     = res_reg;
        out_next     = out_reg && !res_ready;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = '{valid: 1'b1, hash: job_reg.key_hash, call_low: job_reg.call_low,
                         call_high: job_reg.call_high, key_len: job_reg.key_len,
                         heard_at: job_reg.time_now};
        case (state_reg)
            hcat_pkg::ST_INIT, hcat_pkg::ST_WIPE:
            begin
                // Walk every slot and drop its valid mark.
                wr_en         = 1'b1;
                wr_data.valid = 1'b0;
                idx_next      = idx_reg + 1'b1;
                if (last)
                    state_next = (state_reg == hcat_pkg::ST_INIT)
                                 ? hcat_pkg::ST_IDLE : hcat_pkg::ST_DONE;
            end
            hcat_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_next     = job;
                    idx_next     = '0;
                    removed_next = '0;
                    found_next   = 1'b0;
                    status_next  = 1'b0;
                    free_ok_next = 1'b0;
                    if (job.keyed || job.cmd == hcat_pkg::CMD_EXPIRE)
                        state_next = hcat_pkg::ST_READ;
                    else if (job.cmd == hcat_pkg::CMD_CLEAR)
                    begin
                        removed_next = total_reg;
                        total_next   = '0;
                        state_next   = hcat_pkg::ST_WIPE;
                    end
                    else
                        state_next = hcat_pkg::ST_DONE;
                end
            end
            hcat_pkg::ST_READ:
                state_next = hcat_pkg::ST_CHECK;
            hcat_pkg::ST_CHECK:
            begin
                state_next = hcat_pkg::ST_READ;
                idx_next   = idx_reg + 1'b1;
                if (job_reg.cmd == hcat_pkg::CMD_EXPIRE)
                begin
                    if (rd_data.valid &&
                        ((age_on && rd_data.heard_at < below) ||
                         rd_data.heard_at > job_reg.time_now))
                    begin
                        wr_en         = 1'b1;
                        wr_data       = rd_data;
                        wr_data.valid = 1'b0;
                        total_next    = total_reg - 1'b1;
                        removed_next  = removed_reg + 1'b1;
                    end
                    if (last)
                        state_next = hcat_pkg::ST_DONE;
                end
                else if (hit)
                begin
                    found_next = 1'b1;
                    if (job_reg.cmd == hcat_pkg::CMD_HEARD)
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data;
                        wr_data.heard_at = job_reg.time_now;
                    end
                    else if (job_reg.cmd == hcat_pkg::CMD_DROP)
                    begin
                        wr_en         = 1'b1;
                        wr_data       = rd_data;
                        wr_data.valid = 1'b0;
                        total_next    = total_reg - 1'b1;
                        removed_next  = CW'(1);
                    end
                    state_next = hcat_pkg::ST_DONE;
                end
                else
                begin
                    if (!rd_data.valid && !free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        free_next    = idx_reg;
                    end
                    if (last)
                        state_next = (job_reg.cmd == hcat_pkg::CMD_HEARD)
                                     ? hcat_pkg::ST_WRITE : hcat_pkg::ST_DONE;
                end
            end
            hcat_pkg::ST_WRITE:
            begin
                if (free_ok_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = free_reg;
                    total_next = total_reg + 1'b1;
                end
                else
                    status_next = 1'b1;
                state_next = hcat_pkg::ST_DONE;
            end
            hcat_pkg::ST_DONE:
            begin
                if (!out_next)
                begin
                    out_next = 1'b1;
                    res_next.found         = found_reg;
                    res_next.status        = status_reg;
                    res_next.entry_count   = 10'(total_reg);
                    res_next.removed_count = 10'(removed_reg);
                    state_next = hcat_pkg::ST_IDLE;
                end
            end
            default:
                state_next = hcat_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hcat_pkg::ST_INIT;
            total_reg   <= '0;
            out_reg     <= 1'b0;
            idx_reg     <= '0;
            free_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            out_reg     <= out_next;
            idx_reg     <= idx_next;
            free_ok_reg <= free_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg <= removed_next;
        free_reg    <= free_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        job_reg     <= job_next;
        res_reg     <= res_next;
    end

endmodule
